// ===== sv/msw_pkg.sv =====
// Shared types and constants for the mode supervisor watchdog block.
package msw_pkg;

  typedef enum logic [2:0] {
    MODE_SIT    = 3'd0,
    MODE_READY  = 3'd1,
    MODE_S2R    = 3'd2,
    MODE_R2S    = 3'd3,
    MODE_SAFETY = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_REQUEST = 3'd1,
    OP_HBEAT   = 3'd2,
    OP_STATE   = 3'd3,
    OP_REPLY   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_TRANS    = 3'd1,
    CAUSE_REQUEST  = 3'd2,
    CAUSE_HB_LOST  = 3'd3,
    CAUSE_ST_LOST  = 3'd4
  } cause_e;

  typedef enum logic [1:0] {
    CFG_TRANS_TICKS = 2'd0,
    CFG_HB_TIMEOUT  = 2'd1,
    CFG_ST_TIMEOUT  = 2'd2,
    CFG_ON_HW       = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] REQ_SIT    = 8'd0;
  localparam logic [7:0] REQ_READY  = 8'd1;
  localparam logic [7:0] REQ_SAFETY = 8'd4;

  localparam int CFG_BITS      = 16;
  localparam int MAX_RESULTS   = 3;
  localparam int RES_DEPTH     = 4;
  localparam int RES_PTR_BITS  = 2;
  localparam int RES_CNT_BITS  = 3;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       switch_valid;
    logic [2:0] switch_target;
    logic [2:0] cause;
    logic       last;
  } res_t;

endpackage

// ===== sv/mode_supervisor_watchdog_fsm.sv =====
// Five-mode supervisor with heartbeat and state-message watchdogs: top level.
// An item is processed in the cycle it is accepted; the supervisor state updates
// at that edge and its one to three results enter a four-entry result queue that
// drains one result per cycle while the output is not stalled. An input item is
// taken whenever the queue holds at most one result, so items with one result
// each flow at one per cycle without output stalls, and a tick's several results
// leave one after another. Results are registered in the queue at acceptance.
module mode_supervisor_watchdog_fsm import msw_pkg::*; #(
  parameter int AGE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [7:0]          requested_mode_i,
  input  logic [2:0]          reply_controller_i,
  input  logic                reply_ok_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          mode_now_o,
  output logic                switch_valid_o,
  output logic [2:0]          switch_target_o,
  output logic [2:0]          cause_o,
  output logic                last_o
);

  logic       accept;
  logic       busy;
  res_t       res [MAX_RESULTS];
  logic [1:0] res_n;
  res_t       head;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  msw_core #(
    .AGE_BITS(AGE_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .accept_i           (accept),
    .op_i               (op_i),
    .requested_mode_i   (requested_mode_i),
    .reply_controller_i (reply_controller_i),
    .reply_ok_i         (reply_ok_i),
    .res_o              (res),
    .res_n_o            (res_n)
  );

  msw_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_n_i    (res_n),
    .push_data_i (res),
    .pop_i       (out_valid_o && !out_stall_i),
    .busy_o      (busy),
    .valid_o     (out_valid_o),
    .data_o      (head)
  );

  assign mode_now_o      = head.mode_now;
  assign switch_valid_o  = head.switch_valid;
  assign switch_target_o = head.switch_target;
  assign cause_o         = head.cause;
  assign last_o          = head.last;

endmodule

// ===== sv/msw_core.sv =====
// Supervisor state, configuration registers and per-item result computation.
module msw_core import msw_pkg::*; #(
  parameter int AGE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [2:0]          op_i,
  input  logic [7:0]          requested_mode_i,
  input  logic [2:0]          reply_controller_i,
  input  logic                reply_ok_i,
  output res_t                res_o [MAX_RESULTS],
  output logic [1:0]          res_n_o
);

  localparam int CW = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  logic [CFG_BITS-1:0] trans_ticks_q, hb_timeout_q, st_timeout_q;
  logic                on_hw_q;

  mode_e               mode_q, mode_d;
  logic [2:0]          active_q, active_d;
  logic [AGE_BITS-1:0] trans_age_q, trans_age_d;
  logic [AGE_BITS-1:0] hb_age_q, hb_age_d;
  logic [AGE_BITS-1:0] st_age_q, st_age_d;
  logic                hb_seen_q, hb_seen_d;
  logic                st_seen_q, st_seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_ticks_q <= CFG_BITS'(50);
      hb_timeout_q  <= CFG_BITS'(10);
      st_timeout_q  <= CFG_BITS'(5);
      on_hw_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TRANS_TICKS: trans_ticks_q <= cfg_data_i;
        CFG_HB_TIMEOUT:  hb_timeout_q  <= cfg_data_i;
        CFG_ST_TIMEOUT:  st_timeout_q  <= cfg_data_i;
        CFG_ON_HW:       on_hw_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SIT;
      active_q    <= 3'(MODE_SIT);
      trans_age_q <= '0;
      hb_age_q    <= '0;
      st_age_q    <= '0;
      hb_seen_q   <= 1'b0;
      st_seen_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      active_q    <= active_d;
      trans_age_q <= trans_age_d;
      hb_age_q    <= hb_age_d;
      st_age_q    <= st_age_d;
      hb_seen_q   <= hb_seen_d;
      st_seen_q   <= st_seen_d;
    end
  end

  function automatic logic [AGE_BITS-1:0] age_step(logic [AGE_BITS-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic res_t make_res(mode_e m, logic [2:0] tgt, cause_e c,
                                    logic [2:0] act);
    res_t r;
    r.mode_now      = 3'(m);
    r.switch_valid  = (tgt != act);
    r.switch_target = (tgt != act) ? tgt : 3'd0;
    r.cause         = 3'(c);
    r.last          = 1'b0;
    return r;
  endfunction

  res_t       cand [MAX_RESULTS];
  logic       cand_v [MAX_RESULTS];
  res_t       res [MAX_RESULTS];
  logic [1:0] k;
  mode_e      m1;
  logic       hb_fire, st_fire;

  always_comb begin
    mode_d      = mode_q;
    active_d    = active_q;
    trans_age_d = trans_age_q;
    hb_age_d    = hb_age_q;
    st_age_d    = st_age_q;
    hb_seen_d   = hb_seen_q;
    st_seen_d   = st_seen_q;
    m1          = mode_q;
    hb_fire     = 1'b0;
    st_fire     = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      cand[i]   = '0;
      cand_v[i] = 1'b0;
    end

    case (op_e'(op_i))
      OP_TICK: begin
        if (hb_seen_q) hb_age_d = age_step(hb_age_q);
        if (st_seen_q) st_age_d = age_step(st_age_q);
        if (mode_q == MODE_S2R || mode_q == MODE_R2S) trans_age_d = age_step(trans_age_q);
        if ((mode_q == MODE_S2R || mode_q == MODE_R2S) &&
            CW'(trans_age_d) >= CW'(trans_ticks_q)) begin
          m1 = (mode_q == MODE_S2R) ? MODE_READY : MODE_SIT;
          cand_v[0] = 1'b1;
          cand[0]   = make_res(m1, 3'(m1), CAUSE_TRANS, active_q);
        end
        if (m1 != MODE_SAFETY) begin
          hb_fire = hb_seen_q && (CW'(hb_age_d) >= CW'(hb_timeout_q));
          st_fire = !on_hw_q && st_seen_q && (CW'(st_age_d) >= CW'(st_timeout_q));
        end
        cand_v[1] = hb_fire;
        cand[1]   = make_res(MODE_SAFETY, 3'(MODE_SAFETY), CAUSE_HB_LOST, active_q);
        cand_v[2] = st_fire;
        cand[2]   = make_res(MODE_SAFETY, 3'(MODE_SAFETY), CAUSE_ST_LOST, active_q);
        mode_d    = (hb_fire || st_fire) ? MODE_SAFETY : m1;
      end
      OP_REQUEST: begin
        if (mode_q != MODE_S2R && mode_q != MODE_R2S) begin
          cand_v[0] = 1'b1;
          if (requested_mode_i == REQ_READY && mode_q == MODE_SIT) begin
            mode_d      = MODE_S2R;
            trans_age_d = '0;
          end else if (requested_mode_i == REQ_SIT && mode_q == MODE_READY) begin
            mode_d      = MODE_R2S;
            trans_age_d = '0;
          end else if (requested_mode_i == REQ_SIT) begin
            mode_d = MODE_SIT;
          end else if (requested_mode_i == REQ_SAFETY) begin
            mode_d = MODE_SAFETY;
          end else begin
            cand_v[0] = 1'b0;
          end
          cand[0] = make_res(mode_d, 3'(mode_d), CAUSE_REQUEST, active_q);
        end
      end
      OP_HBEAT: begin
        hb_age_d  = '0;
        hb_seen_d = 1'b1;
      end
      OP_STATE: begin
        st_age_d  = '0;
        st_seen_d = 1'b1;
      end
      OP_REPLY: begin
        if (reply_ok_i && reply_controller_i <= 3'(MODE_SAFETY)) active_d = reply_controller_i;
      end
      default: ;
    endcase

    for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
    k = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (cand_v[i]) begin
        res[k] = cand[i];
        k      = k + 2'd1;
      end
    end
    if (k == 2'd0) begin
      res[0]          = '0;
      res[0].mode_now = 3'(mode_d);
      k               = 2'd1;
    end
    res[k - 2'd1].last = 1'b1;
  end

  assign res_o   = res;
  assign res_n_o = k;

endmodule

// ===== sv/msw_res_fifo.sv =====
// Result queue: takes up to three results per item, hands out one per cycle while popped.
module msw_res_fifo import msw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] push_n_i,
  input  res_t       push_data_i [MAX_RESULTS],
  input  logic       pop_i,
  output logic       busy_o,
  output logic       valid_o,
  output res_t       data_o
);

  res_t                    mem_q [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_q, rd_q;
  logic [RES_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]              n_push;

  assign n_push = push_i ? push_n_i : 2'd0;
  assign cnt_d  = cnt_q + RES_CNT_BITS'(n_push) - RES_CNT_BITS'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RES_PTR_BITS'(n_push);
      rd_q  <= rd_q + RES_PTR_BITS'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < n_push) mem_q[wr_q + RES_PTR_BITS'(i)] <= push_data_i[i];
    end
  end

  // Room for a full three-result item is required before the next item.
  assign busy_o  = cnt_q > RES_CNT_BITS'(RES_DEPTH - MAX_RESULTS);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the mode supervisor: directed item table, then random items checked by a predictor.
`timescale 1ns / 100ps
module tb_top;
  import msw_pkg::*;

  localparam int AGE_BITS = 16;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_MID = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam logic [2:0] CTRL_BAD_LO = 3'd5;
  localparam logic [2:0] CTRL_BAD_HI = 3'd7;
  localparam logic [7:0] REQ_BAD_S2R = 8'd2;
  localparam logic [7:0] REQ_BAD_R2S = 8'd3;
  localparam logic [7:0] REQ_BAD_MAX = 8'hFF;

  localparam res_t NO_RES = '0;
  localparam res_t SIT_IDLE = '{MODE_SIT, 1'b0, 3'd0, CAUSE_NONE, 1'b1};
  localparam res_t SIT_KEEP = '{MODE_SIT, 1'b0, 3'd0, CAUSE_REQUEST, 1'b1};
  localparam res_t GO_S2R = '{MODE_S2R, 1'b1, MODE_S2R, CAUSE_REQUEST, 1'b1};
  localparam res_t S2R_IDLE = '{MODE_S2R, 1'b0, 3'd0, CAUSE_NONE, 1'b1};

  typedef struct {
    logic [2:0] op;
    logic [7:0] req;
    logic [2:0] rc;
    logic       ok;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [2:0]          op_i = '0;
  logic [7:0]          requested_mode_i = '0;
  logic [2:0]          reply_controller_i = '0;
  logic                reply_ok_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          mode_now_o;
  logic                switch_valid_o;
  logic [2:0]          switch_target_o;
  logic [2:0]          cause_o;
  logic                last_o;

  mode_supervisor_watchdog_fsm #(.AGE_BITS(AGE_BITS)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // supervisor copy
  mode_e               sup_mode = MODE_SIT;
  logic [2:0]          sup_active = MODE_SIT;
  logic [2:0]          sup_last_target = MODE_SIT;
  logic [AGE_BITS-1:0] trans_age = '0;
  logic [AGE_BITS-1:0] hb_age = '0;
  logic [AGE_BITS-1:0] st_age = '0;
  bit                  hb_seen = 1'b0;
  bit                  st_seen = 1'b0;
  logic [15:0]         lim_trans = 16'd50;
  logic [15:0]         lim_hb = 16'd10;
  logic [15:0]         lim_st = 16'd5;
  logic                on_hw = 1'b0;

  res_t      step_res [MAX_RESULTS];
  int        step_cnt;
  res_t      pending_results [$];
  stim_row_t directed_rows [$];
  int        zero_limits_at;
  int        err_count = 0;
  int        results_seen = 0;
  bit        no_idle = 1'b0;
  int        stall_left = 0;

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("[%0t] result %0d: MISMATCH %s", $time, results_seen, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic expect_result(input res_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endtask

  function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  task automatic push_result(input cause_e why, input logic [2:0] target);
    res_t r;
    r.mode_now = sup_mode;
    r.switch_valid = (target != sup_active);
    r.switch_target = r.switch_valid ? target : 3'd0;
    r.cause = why;
    r.last = 1'b0;
    if (r.switch_valid) sup_last_target = target;
    step_res[step_cnt] = r;
    step_cnt++;
  endtask

  task automatic predict_item(input logic [2:0] op, input logic [7:0] req,
                              input logic [2:0] rc, input logic ok);
    step_cnt = 0;
    case (op)
      OP_TICK: begin
        if (hb_seen) hb_age = age_inc(hb_age);
        if (st_seen) st_age = age_inc(st_age);
        if (sup_mode == MODE_S2R || sup_mode == MODE_R2S) trans_age = age_inc(trans_age);
        if (sup_mode == MODE_S2R && trans_age >= lim_trans) begin
          sup_mode = MODE_READY;
          push_result(CAUSE_TRANS, MODE_READY);
        end else if (sup_mode == MODE_R2S && trans_age >= lim_trans) begin
          sup_mode = MODE_SIT;
          push_result(CAUSE_TRANS, MODE_SIT);
        end
        if (sup_mode != MODE_SAFETY) begin
          if (hb_seen && hb_age >= lim_hb) begin
            sup_mode = MODE_SAFETY;
            push_result(CAUSE_HB_LOST, MODE_SAFETY);
          end
          if (!on_hw && st_seen && st_age >= lim_st) begin
            sup_mode = MODE_SAFETY;
            push_result(CAUSE_ST_LOST, MODE_SAFETY);
          end
        end
      end
      OP_REQUEST: begin
        if (sup_mode != MODE_S2R && sup_mode != MODE_R2S) begin
          if (req == REQ_READY && sup_mode == MODE_SIT) begin
            sup_mode = MODE_S2R;
            trans_age = '0;
            push_result(CAUSE_REQUEST, MODE_S2R);
          end else if (req == REQ_SIT && sup_mode == MODE_READY) begin
            sup_mode = MODE_R2S;
            trans_age = '0;
            push_result(CAUSE_REQUEST, MODE_R2S);
          end else if (req == REQ_SIT) begin
            sup_mode = MODE_SIT;
            push_result(CAUSE_REQUEST, MODE_SIT);
          end else if (req == REQ_SAFETY) begin
            sup_mode = MODE_SAFETY;
            push_result(CAUSE_REQUEST, MODE_SAFETY);
          end
        end
      end
      OP_HBEAT: begin
        hb_age = '0;
        hb_seen = 1'b1;
      end
      OP_STATE: begin
        st_age = '0;
        st_seen = 1'b1;
      end
      OP_REPLY: begin
        if (ok && rc <= MODE_SAFETY) sup_active = rc;
      end
      default: ;
    endcase
    if (step_cnt == 0) begin
      step_res[0] = '0;
      step_res[0].mode_now = sup_mode;
      step_cnt = 1;
    end
    step_res[step_cnt-1].last = 1'b1;
  endtask

  function automatic stim_row_t make_row(input logic [2:0] op, input logic [7:0] req,
                                         input logic [2:0] rc, input logic ok,
                                         input bit typed, input res_t want);
    stim_row_t row;
    row.op = op;
    row.req = req;
    row.rc = rc;
    row.ok = ok;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // mostly well-formed traffic; replies acknowledge the latest switch
  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    pick = $urandom_range(0, 99);
    row = make_row(OP_TICK, 8'($urandom), 3'($urandom), 1'($urandom), 1'b0, NO_RES);
    if (pick < 35) begin
      row.op = OP_TICK;
    end else if (pick < 50) begin
      row.op = OP_HBEAT;
    end else if (pick < 62) begin
      row.op = OP_STATE;
    end else if (pick < 77) begin
      row.op = OP_REQUEST;
      case ($urandom_range(0, 5))
        0, 1: row.req = REQ_SIT;
        2, 3: row.req = REQ_READY;
        4: row.req = REQ_SAFETY;
        default: ;
      endcase
    end else if (pick < 92) begin
      row.op = OP_REPLY;
      row.rc = sup_last_target;
      row.ok = ($urandom_range(0, 4) != 0);
    end else begin
      row.op = 3'($urandom_range(0, 7));
    end
    return row;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic send_item(input stim_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= row.op;
    requested_mode_i <= row.req;
    reply_controller_i <= row.rc;
    reply_ok_i <= row.ok;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(row.op, row.req, row.rc, row.ok);
    if (row.typed) begin
      expect_result(row.want);
    end else begin
      for (int k = 0; k < step_cnt; k++) expect_result(step_res[k]);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] t, input logic [15:0] h,
                              input logic [15:0] s, input logic hw);
    logic [15:0] vals [4];
    vals[CFG_TRANS_TICKS] = t;
    vals[CFG_HB_TIMEOUT] = h;
    vals[CFG_ST_TIMEOUT] = s;
    vals[CFG_ON_HW] = {15'd0, hw};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    lim_trans = t;
    lim_hb = h;
    lim_st = s;
    on_hw = hw;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        stall_left = no_idle ? 0 : $urandom_range(0, 5);
        out_stall_i <= (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result mode %0d cause %0d", mode_now_o, cause_o));
      end else begin
        want = pending_results.pop_front();
        check_field("mode_now", mode_now_o, want.mode_now);
        check_field("switch_valid", 3'(switch_valid_o), 3'(want.switch_valid));
        check_field("switch_target", switch_target_o, want.switch_target);
        check_field("cause", cause_o, want.cause);
        check_field("last", 3'(last_o), 3'(want.last));
      end
      results_seen++;
    end
  end

  initial begin
    int waited;
    add_row(make_row(OP_TICK, REQ_SIT, 3'd0, 1'b0, 1'b1, SIT_IDLE));
    add_row(make_row(OP_BAD_HI, REQ_BAD_MAX, CTRL_BAD_HI, 1'b1, 1'b1, SIT_IDLE));
    add_row(make_row(OP_BAD_LO, REQ_SIT, 3'd0, 1'b0, 1'b1, SIT_IDLE));
    add_row(make_row(OP_BAD_MID, REQ_READY, CTRL_BAD_LO, 1'b1, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REQUEST, REQ_BAD_S2R, 3'd0, 1'b0, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REQUEST, REQ_BAD_R2S, 3'd0, 1'b0, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REQUEST, REQ_BAD_MAX, 3'd0, 1'b0, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REPLY, REQ_SIT, CTRL_BAD_HI, 1'b1, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REPLY, REQ_SIT, CTRL_BAD_LO, 1'b1, 1'b1, SIT_IDLE));
    add_row(make_row(OP_REQUEST, REQ_SIT, 3'd0, 1'b0, 1'b1, SIT_KEEP));
    add_row(make_row(OP_REQUEST, REQ_READY, 3'd0, 1'b0, 1'b1, GO_S2R));
    add_row(make_row(OP_REQUEST, REQ_SAFETY, 3'd0, 1'b0, 1'b1, S2R_IDLE));
    add_row(make_row(OP_REPLY, REQ_SIT, MODE_S2R, 1'b0, 1'b0, NO_RES));
    add_row(make_row(OP_REPLY, REQ_SIT, MODE_S2R, 1'b1, 1'b0, NO_RES));
    add_row(make_row(OP_HBEAT, REQ_SIT, 3'd0, 1'b0, 1'b0, NO_RES));
    add_row(make_row(OP_STATE, REQ_SIT, 3'd0, 1'b0, 1'b0, NO_RES));
    // fifth tick trips the state watchdog
    repeat (5) add_row(make_row(OP_TICK, REQ_SIT, 3'd0, 1'b0, 1'b0, NO_RES));
    add_row(make_row(OP_REQUEST, REQ_SIT, 3'd0, 1'b0, 1'b0, NO_RES));
    add_row(make_row(OP_REQUEST, REQ_READY, 3'd0, 1'b0, 1'b0, NO_RES));
    // zero limits: transition done and both watchdogs on one tick
    zero_limits_at = directed_rows.size();
    add_row(make_row(OP_TICK, REQ_SIT, 3'd0, 1'b0, 1'b0, NO_RES));
    add_row(make_row(OP_REQUEST, REQ_SAFETY, 3'd0, 1'b0, 1'b0, NO_RES));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (i == zero_limits_at) begin
        settle();
        write_config('0, '0, '0, 1'b0);
      end
      send_item(directed_rows[i]);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 0) write_config('1, '1, '1, 1'b1);
      else write_config(pick_limit(), pick_limit(), pick_limit(), 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (40) send_item(random_row());
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
